// ===== src/rv64i_instruction_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// RV64I decoder assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RV64I_INSTRUCTION_DECODER_DEFINES_SVH
`define RV64I_INSTRUCTION_DECODER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RV64DEC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rv64dec: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RV64DEC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rv64dec: next-cycle check failed");

`endif

// ===== src/rv64dec_pkg.sv =====
// ----------------------------------------------------------------------------
// RV64I decoder package
// Operation numbers, error codes, opcodes and the decode control structure.
// ----------------------------------------------------------------------------
`default_nettype none

package rv64dec_pkg;

  localparam logic [6:0] OPC_LUI      = 7'h37;
  localparam logic [6:0] OPC_AUIPC    = 7'h17;
  localparam logic [6:0] OPC_JAL      = 7'h6f;
  localparam logic [6:0] OPC_JALR     = 7'h67;
  localparam logic [6:0] OPC_BRANCH   = 7'h63;
  localparam logic [6:0] OPC_LOAD     = 7'h03;
  localparam logic [6:0] OPC_STORE    = 7'h23;
  localparam logic [6:0] OPC_OP_IMM   = 7'h13;
  localparam logic [6:0] OPC_OP       = 7'h33;
  localparam logic [6:0] OPC_OP_IMM32 = 7'h1b;
  localparam logic [6:0] OPC_OP_32    = 7'h3b;
  localparam logic [6:0] OPC_MISC_MEM = 7'h0f;
  localparam logic [6:0] OPC_SYSTEM   = 7'h73;

  localparam logic [1:0]  FULL_SIZE_LSBS = 2'b11;
  localparam logic [6:0]  FUNCT7_ZERO    = 7'h00;
  localparam logic [6:0]  FUNCT7_ALT     = 7'h20;
  localparam logic [5:0]  SHIFT6_LOGIC   = 6'h00;
  localparam logic [5:0]  SHIFT6_ARITH   = 6'h10;
  localparam logic [31:0] SFENCE_MASK    = 32'hfe007fff;
  localparam logic [31:0] SFENCE_MATCH   = 32'h12000073;
  localparam logic [31:0] WORD_ECALL     = 32'h00000073;
  localparam logic [31:0] WORD_EBREAK    = 32'h00100073;
  localparam logic [31:0] WORD_SRET      = 32'h10200073;
  localparam logic [31:0] WORD_MRET      = 32'h30200073;
  localparam logic [31:0] WORD_WFI       = 32'h10500073;
  localparam logic [31:0] WORD_FENCE_I   = 32'h0000100f;

  typedef enum logic [5:0] {
    OP_LUI, OP_AUIPC, OP_JAL, OP_JALR,
    OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU,
    OP_LB, OP_LH, OP_LW, OP_LD, OP_LBU, OP_LHU, OP_LWU,
    OP_SB, OP_SH, OP_SW, OP_SD,
    OP_ADDI, OP_SLTI, OP_SLTIU, OP_XORI, OP_ORI, OP_ANDI, OP_SLLI, OP_SRLI, OP_SRAI,
    OP_ADD, OP_SUB, OP_SLL, OP_SLT, OP_SLTU, OP_XOR, OP_SRL, OP_SRA, OP_OR, OP_AND,
    OP_ADDIW, OP_SLLIW, OP_SRLIW, OP_SRAIW,
    OP_ADDW, OP_SUBW, OP_SLLW, OP_SRLW, OP_SRAW,
    OP_FENCE, OP_FENCE_I, OP_SFENCE_VMA,
    OP_ECALL, OP_EBREAK, OP_SRET, OP_MRET, OP_WFI,
    OP_CSRRW, OP_CSRRS, OP_CSRRC, OP_CSRRWI, OP_CSRRSI, OP_CSRRCI
  } op_t;

  typedef enum logic [3:0] {
    ERR_COMPRESSED, ERR_OPCODE, ERR_JALR, ERR_BRANCH, ERR_LOAD, ERR_STORE,
    ERR_SLLI, ERR_SHIFT_RIGHT_IMM, ERR_ALT_OP, ERR_OP_EXT, ERR_OP_IMM32,
    ERR_ALT_OP32, ERR_OP32_EXT, ERR_OP32_FUNCT3, ERR_MISC_MEM, ERR_SYSTEM
  } err_t;

  typedef enum logic [2:0] {
    IMM_NONE, IMM_I, IMM_S, IMM_B, IMM_U, IMM_J, IMM_SHAMT6, IMM_SHAMT5
  } imm_kind_t;

  typedef struct packed {
    logic      is_error;
    err_t      error_code;
    op_t       operation;
    imm_kind_t imm_kind;
  } dec_ctl_t;

endpackage

`default_nettype wire

// ===== src/rv64dec_classify.sv =====
// ----------------------------------------------------------------------------
// RV64I decoder classifier
// Maps an instruction word to its operation, error code and immediate format.
// ----------------------------------------------------------------------------
`default_nettype none

module rv64dec_classify (
  input  wire logic [31:0]           word,
  output rv64dec_pkg::dec_ctl_t      ctl
);
  import rv64dec_pkg::*;

  logic [6:0] opcode;
  logic [2:0] funct3;
  logic [6:0] funct7;
  logic [5:0] top6;

  assign opcode = word[6:0];
  assign funct3 = word[14:12];
  assign funct7 = word[31:25];
  assign top6   = word[31:26];

  always_comb begin
    // A successful decode leaves the error code at its zero value.
    ctl.is_error   = 1'b0;
    ctl.error_code = ERR_COMPRESSED;
    ctl.operation  = OP_LUI;
    ctl.imm_kind   = IMM_NONE;
    if (word[1:0] != FULL_SIZE_LSBS) begin
      ctl.is_error = 1'b1;
    end else begin
      unique case (opcode)
        OPC_LUI: begin
          ctl.operation = OP_LUI;
          ctl.imm_kind  = IMM_U;
        end
        OPC_AUIPC: begin
          ctl.operation = OP_AUIPC;
          ctl.imm_kind  = IMM_U;
        end
        OPC_JAL: begin
          ctl.operation = OP_JAL;
          ctl.imm_kind  = IMM_J;
        end
        OPC_JALR: begin
          if (funct3 == 3'd0) begin
            ctl.operation = OP_JALR;
            ctl.imm_kind  = IMM_I;
          end else begin
            ctl.is_error   = 1'b1;
            ctl.error_code = ERR_JALR;
          end
        end
        OPC_BRANCH: begin
          ctl.imm_kind = IMM_B;
          unique case (funct3)
            3'd0: ctl.operation = OP_BEQ;
            3'd1: ctl.operation = OP_BNE;
            3'd4: ctl.operation = OP_BLT;
            3'd5: ctl.operation = OP_BGE;
            3'd6: ctl.operation = OP_BLTU;
            3'd7: ctl.operation = OP_BGEU;
            default: begin
              ctl.is_error   = 1'b1;
              ctl.error_code = ERR_BRANCH;
              ctl.imm_kind   = IMM_NONE;
            end
          endcase
        end
        OPC_LOAD: begin
          ctl.imm_kind = IMM_I;
          unique case (funct3)
            3'd0: ctl.operation = OP_LB;
            3'd1: ctl.operation = OP_LH;
            3'd2: ctl.operation = OP_LW;
            3'd3: ctl.operation = OP_LD;
            3'd4: ctl.operation = OP_LBU;
            3'd5: ctl.operation = OP_LHU;
            3'd6: ctl.operation = OP_LWU;
            default: begin
              ctl.is_error   = 1'b1;
              ctl.error_code = ERR_LOAD;
              ctl.imm_kind   = IMM_NONE;
            end
          endcase
        end
        OPC_STORE: begin
          ctl.imm_kind = IMM_S;
          unique case (funct3)
            3'd0: ctl.operation = OP_SB;
            3'd1: ctl.operation = OP_SH;
            3'd2: ctl.operation = OP_SW;
            3'd3: ctl.operation = OP_SD;
            default: begin
              ctl.is_error   = 1'b1;
              ctl.error_code = ERR_STORE;
              ctl.imm_kind   = IMM_NONE;
            end
          endcase
        end
        OPC_OP_IMM: begin
          ctl.imm_kind = IMM_I;
          unique case (funct3)
            3'd0: ctl.operation = OP_ADDI;
            3'd2: ctl.operation = OP_SLTI;
            3'd3: ctl.operation = OP_SLTIU;
            3'd4: ctl.operation = OP_XORI;
            3'd6: ctl.operation = OP_ORI;
            3'd7: ctl.operation = OP_ANDI;
            3'd1: begin
              if (top6 == SHIFT6_LOGIC) begin
                ctl.operation = OP_SLLI;
                ctl.imm_kind  = IMM_SHAMT6;
              end else begin
                ctl.is_error   = 1'b1;
                ctl.error_code = ERR_SLLI;
                ctl.imm_kind   = IMM_NONE;
              end
            end
            default: begin
              if (top6 == SHIFT6_LOGIC) begin
                ctl.operation = OP_SRLI;
                ctl.imm_kind  = IMM_SHAMT6;
              end else if (top6 == SHIFT6_ARITH) begin
                ctl.operation = OP_SRAI;
                ctl.imm_kind  = IMM_SHAMT6;
              end else begin
                ctl.is_error   = 1'b1;
                ctl.error_code = ERR_SHIFT_RIGHT_IMM;
                ctl.imm_kind   = IMM_NONE;
              end
            end
          endcase
        end
        OPC_OP: begin
          if (funct7 == FUNCT7_ALT) begin
            if (funct3 == 3'd0) begin
              ctl.operation = OP_SUB;
            end else if (funct3 == 3'd5) begin
              ctl.operation = OP_SRA;
            end else begin
              ctl.is_error   = 1'b1;
              ctl.error_code = ERR_ALT_OP;
            end
          end else if (funct7 != FUNCT7_ZERO) begin
            ctl.is_error   = 1'b1;
            ctl.error_code = ERR_OP_EXT;
          end else begin
            unique case (funct3)
              3'd0: ctl.operation = OP_ADD;
              3'd1: ctl.operation = OP_SLL;
              3'd2: ctl.operation = OP_SLT;
              3'd3: ctl.operation = OP_SLTU;
              3'd4: ctl.operation = OP_XOR;
              3'd5: ctl.operation = OP_SRL;
              3'd6: ctl.operation = OP_OR;
              default: ctl.operation = OP_AND;
            endcase
          end
        end
        OPC_OP_IMM32: begin
          if (funct3 == 3'd0) begin
            ctl.operation = OP_ADDIW;
            ctl.imm_kind  = IMM_I;
          end else if (funct3 == 3'd1 && funct7 == FUNCT7_ZERO) begin
            ctl.operation = OP_SLLIW;
            ctl.imm_kind  = IMM_SHAMT5;
          end else if (funct3 == 3'd5 && funct7 == FUNCT7_ZERO) begin
            ctl.operation = OP_SRLIW;
            ctl.imm_kind  = IMM_SHAMT5;
          end else if (funct3 == 3'd5 && funct7 == FUNCT7_ALT) begin
            ctl.operation = OP_SRAIW;
            ctl.imm_kind  = IMM_SHAMT5;
          end else begin
            ctl.is_error   = 1'b1;
            ctl.error_code = ERR_OP_IMM32;
          end
        end
        OPC_OP_32: begin
          if (funct7 == FUNCT7_ALT) begin
            if (funct3 == 3'd0) begin
              ctl.operation = OP_SUBW;
            end else if (funct3 == 3'd5) begin
              ctl.operation = OP_SRAW;
            end else begin
              ctl.is_error   = 1'b1;
              ctl.error_code = ERR_ALT_OP32;
            end
          end else if (funct7 != FUNCT7_ZERO) begin
            ctl.is_error   = 1'b1;
            ctl.error_code = ERR_OP32_EXT;
          end else if (funct3 == 3'd0) begin
            ctl.operation = OP_ADDW;
          end else if (funct3 == 3'd1) begin
            ctl.operation = OP_SLLW;
          end else if (funct3 == 3'd5) begin
            ctl.operation = OP_SRLW;
          end else begin
            ctl.is_error   = 1'b1;
            ctl.error_code = ERR_OP32_FUNCT3;
          end
        end
        OPC_MISC_MEM: begin
          if (funct3 == 3'd0) begin
            ctl.operation = OP_FENCE;
          end else if (word == WORD_FENCE_I) begin
            ctl.operation = OP_FENCE_I;
          end else begin
            ctl.is_error   = 1'b1;
            ctl.error_code = ERR_MISC_MEM;
          end
        end
        OPC_SYSTEM: begin
          unique case (funct3)
            3'd0: begin
              if ((word & SFENCE_MASK) == SFENCE_MATCH) begin
                ctl.operation = OP_SFENCE_VMA;
              end else if (word == WORD_ECALL) begin
                ctl.operation = OP_ECALL;
              end else if (word == WORD_EBREAK) begin
                ctl.operation = OP_EBREAK;
              end else if (word == WORD_SRET) begin
                ctl.operation = OP_SRET;
              end else if (word == WORD_MRET) begin
                ctl.operation = OP_MRET;
              end else if (word == WORD_WFI) begin
                ctl.operation = OP_WFI;
              end else begin
                ctl.is_error   = 1'b1;
                ctl.error_code = ERR_SYSTEM;
              end
            end
            3'd1: ctl.operation = OP_CSRRW;
            3'd2: ctl.operation = OP_CSRRS;
            3'd3: ctl.operation = OP_CSRRC;
            3'd5: ctl.operation = OP_CSRRWI;
            3'd6: ctl.operation = OP_CSRRSI;
            3'd7: ctl.operation = OP_CSRRCI;
            default: begin
              ctl.is_error   = 1'b1;
              ctl.error_code = ERR_SYSTEM;
            end
          endcase
        end
        default: begin
          ctl.is_error   = 1'b1;
          ctl.error_code = ERR_OPCODE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/rv64dec_imm_gen.sv =====
// ----------------------------------------------------------------------------
// RV64I decoder immediate generator
// Assembles the sign-extended immediate or shift amount for a given format.
// ----------------------------------------------------------------------------
`default_nettype none

module rv64dec_imm_gen (
  input  wire logic [31:0]              word,
  input  wire rv64dec_pkg::imm_kind_t   imm_kind,
  output logic signed [31:0]            imm
);
  import rv64dec_pkg::*;

  always_comb begin
    unique case (imm_kind)
      IMM_I:      imm = {{20{word[31]}}, word[31:20]};
      IMM_S:      imm = {{20{word[31]}}, word[31:25], word[11:7]};
      IMM_B:      imm = {{20{word[31]}}, word[7], word[30:25], word[11:8], 1'b0};
      IMM_U:      imm = {word[31:12], 12'h000};
      IMM_J:      imm = {{12{word[31]}}, word[19:12], word[20], word[30:21], 1'b0};
      IMM_SHAMT6: imm = {26'd0, word[25:20]};
      IMM_SHAMT5: imm = {27'd0, word[24:20]};
      default:    imm = 32'sd0;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/rv64i_instruction_decoder.sv =====
// ----------------------------------------------------------------------------
// RV64I instruction decoder
// Decodes RV64I, fence, CSR and privileged words into operation, register
// fields, immediate and error information.
//
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid / in_stall   instruction_word
//   out_     output     out_valid / out_stall decoded fields and word echo
//
// One transaction is taken per cycle while in_stall is low; an accepted word
// passes through an input register and then a result register.
// Reset clears only the two valid flags; payload registers are not reset.
// The input register holds one further transaction while a result is stalled.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rv64i_instruction_decoder_defines.svh"

module rv64i_instruction_decoder (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [31:0]        in_instruction_word,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_is_error,
  output logic [3:0]              out_error_code,
  output logic [5:0]              out_operation_code,
  output logic [4:0]              out_dest_reg,
  output logic [4:0]              out_src1_reg,
  output logic [4:0]              out_src2_reg,
  output logic signed [31:0]      out_imm_value,
  output logic [11:0]             out_csr_number,
  output logic [31:0]             out_word_echo
);
  import rv64dec_pkg::*;

  logic               s1_valid_r;
  logic               s1_valid_nxt;
  logic [31:0]        s1_word_r;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic               out_ready;
  logic               s1_ready;
  logic               s1_load;
  logic               out_load;
  dec_ctl_t           ctl;
  logic signed [31:0] imm;
  logic               is_error_r;
  logic [3:0]         error_code_r;
  logic [5:0]         operation_r;
  logic signed [31:0] imm_r;
  logic [31:0]        word_r;

  rv64dec_classify u_classify (
    .word (s1_word_r),
    .ctl  (ctl)
  );

  rv64dec_imm_gen u_imm_gen (
    .word     (s1_word_r),
    .imm_kind (ctl.imm_kind),
    .imm      (imm)
  );

  assign out_ready     = !out_valid_r || !out_stall;
  assign s1_ready      = !s1_valid_r || out_ready;
  assign in_stall      = !s1_ready;
  assign s1_load       = in_valid && s1_ready;
  assign out_load      = s1_valid_r && out_ready;
  assign s1_valid_nxt  = s1_load ? 1'b1 : (out_ready ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = out_ready ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_word_r <= in_instruction_word;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      is_error_r   <= ctl.is_error;
      error_code_r <= ctl.error_code;
      operation_r  <= ctl.operation;
      imm_r        <= imm;
      word_r       <= s1_word_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_is_error       = is_error_r;
  assign out_error_code     = error_code_r;
  assign out_operation_code = operation_r;
  assign out_dest_reg       = word_r[11:7];
  assign out_src1_reg       = word_r[19:15];
  assign out_src2_reg       = word_r[24:20];
  assign out_imm_value      = imm_r;
  assign out_csr_number     = word_r[31:20];
  assign out_word_echo      = word_r;

  `RV64DEC_ASSERT_SAME(a_error_clears_op, out_valid_r && is_error_r, operation_r == OP_LUI && imm_r == 32'sd0)
  `RV64DEC_ASSERT_SAME(a_success_code_zero, out_valid_r && !is_error_r, error_code_r == ERR_COMPRESSED)
  `RV64DEC_ASSERT_SAME(a_stall_needs_held, in_stall, s1_valid_r && out_valid_r && out_stall)
  `RV64DEC_ASSERT_NEXT(a_word_advances, s1_valid_r && out_ready, out_valid_r && word_r == $past(s1_word_r))
  `RV64DEC_ASSERT_SAME(a_compressed_flagged, out_valid_r && word_r[1:0] != FULL_SIZE_LSBS, is_error_r)

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RV64I instruction decoder testbench
// Drives instruction words through the valid/stall input channel and checks
// every decoded result against an in-bench decoder, in order. A short
// directed set of boundary and special words is followed by a sweep over
// every operation, a drain pause, random well-formed, broken and noise
// words with random idling on both sides, a stretch with no idling and more random words.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import rv64dec_pkg::*;

  typedef struct packed {
    logic        is_error;
    err_t        error_code;
    op_t         operation;
    logic [4:0]  dest_reg;
    logic [4:0]  src1_reg;
    logic [4:0]  src2_reg;
    logic [31:0] imm_value;
    logic [11:0] csr_number;
    logic [31:0] word_echo;
  } decoded_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_instruction_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_is_error;
  logic [3:0]  out_error_code;
  logic [5:0]  out_operation_code;
  logic [4:0]  out_dest_reg;
  logic [4:0]  out_src1_reg;
  logic [4:0]  out_src2_reg;
  logic signed [31:0] out_imm_value;
  logic [11:0] out_csr_number;
  logic [31:0] out_word_echo;

  decoded_t pending_decodes[$];
  int       fail_count = 0;
  bit       sender_idles = 1'b1;
  bit       receiver_idles = 1'b1;

  rv64i_instruction_decoder dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_instruction_word (in_instruction_word),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_is_error        (out_is_error),
    .out_error_code      (out_error_code),
    .out_operation_code  (out_operation_code),
    .out_dest_reg        (out_dest_reg),
    .out_src1_reg        (out_src1_reg),
    .out_src2_reg        (out_src2_reg),
    .out_imm_value       (out_imm_value),
    .out_csr_number      (out_csr_number),
    .out_word_echo       (out_word_echo)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("rv64i_instruction_decoder verification failed");
    $finish;
  end

  function automatic decoded_t decode_expected(input logic [31:0] w);
    decoded_t    d;
    logic        ok;
    err_t        err;
    op_t         op;
    logic [31:0] imm;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] imm_i;
    f3 = w[14:12];
    f7 = w[31:25];
    imm_i = {{20{w[31]}}, w[31:20]};
    ok = 1'b0;
    err = ERR_OPCODE;
    op = OP_LUI;
    imm = '0;
    if (w[1:0] != FULL_SIZE_LSBS) begin
      err = ERR_COMPRESSED;
    end else begin
      case (w[6:0])
        OPC_LUI: begin
          ok = 1'b1; op = OP_LUI; imm = {w[31:12], 12'b0};
        end
        OPC_AUIPC: begin
          ok = 1'b1; op = OP_AUIPC; imm = {w[31:12], 12'b0};
        end
        OPC_JAL: begin
          ok = 1'b1; op = OP_JAL;
          imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        end
        OPC_JALR: begin
          if (f3 == 3'd0) begin
            ok = 1'b1; op = OP_JALR; imm = imm_i;
          end else begin
            err = ERR_JALR;
          end
        end
        OPC_BRANCH: begin
          if (f3 == 3'd2 || f3 == 3'd3) begin
            err = ERR_BRANCH;
          end else begin
            ok = 1'b1;
            op = (f3 < 3'd2) ? op_t'(6'(OP_BEQ) + 6'(f3)) : op_t'(6'(OP_BLT) + 6'(f3) - 6'd4);
            imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
          end
        end
        OPC_LOAD: begin
          if (f3 == 3'd7) begin
            err = ERR_LOAD;
          end else begin
            ok = 1'b1; op = op_t'(6'(OP_LB) + 6'(f3)); imm = imm_i;
          end
        end
        OPC_STORE: begin
          if (f3 > 3'd3) begin
            err = ERR_STORE;
          end else begin
            ok = 1'b1; op = op_t'(6'(OP_SB) + 6'(f3));
            imm = {{20{w[31]}}, w[31:25], w[11:7]};
          end
        end
        OPC_OP_IMM: begin
          ok = 1'b1;
          imm = imm_i;
          case (f3)
            3'd0: op = OP_ADDI;
            3'd2: op = OP_SLTI;
            3'd3: op = OP_SLTIU;
            3'd4: op = OP_XORI;
            3'd6: op = OP_ORI;
            3'd7: op = OP_ANDI;
            3'd1: begin
              imm = {26'b0, w[25:20]};
              op = OP_SLLI;
              if (w[31:26] != SHIFT6_LOGIC) begin
                ok = 1'b0; err = ERR_SLLI;
              end
            end
            default: begin
              imm = {26'b0, w[25:20]};
              if (w[31:26] == SHIFT6_LOGIC) begin
                op = OP_SRLI;
              end else if (w[31:26] == SHIFT6_ARITH) begin
                op = OP_SRAI;
              end else begin
                ok = 1'b0; err = ERR_SHIFT_RIGHT_IMM;
              end
            end
          endcase
        end
        OPC_OP: begin
          if (f7 == FUNCT7_ALT) begin
            ok = 1'b1;
            if (f3 == 3'd0) op = OP_SUB;
            else if (f3 == 3'd5) op = OP_SRA;
            else begin
              ok = 1'b0; err = ERR_ALT_OP;
            end
          end else if (f7 != FUNCT7_ZERO) begin
            err = ERR_OP_EXT;
          end else begin
            ok = 1'b1;
            case (f3)
              3'd0: op = OP_ADD;
              3'd1: op = OP_SLL;
              3'd2: op = OP_SLT;
              3'd3: op = OP_SLTU;
              3'd4: op = OP_XOR;
              3'd5: op = OP_SRL;
              3'd6: op = OP_OR;
              default: op = OP_AND;
            endcase
          end
        end
        OPC_OP_IMM32: begin
          ok = 1'b1;
          imm = {27'b0, w[24:20]};
          if (f3 == 3'd0) begin
            op = OP_ADDIW; imm = imm_i;
          end else if (f3 == 3'd1 && f7 == FUNCT7_ZERO) op = OP_SLLIW;
          else if (f3 == 3'd5 && f7 == FUNCT7_ZERO) op = OP_SRLIW;
          else if (f3 == 3'd5 && f7 == FUNCT7_ALT) op = OP_SRAIW;
          else begin
            ok = 1'b0; err = ERR_OP_IMM32;
          end
        end
        OPC_OP_32: begin
          if (f7 == FUNCT7_ALT) begin
            ok = 1'b1;
            if (f3 == 3'd0) op = OP_SUBW;
            else if (f3 == 3'd5) op = OP_SRAW;
            else begin
              ok = 1'b0; err = ERR_ALT_OP32;
            end
          end else if (f7 != FUNCT7_ZERO) begin
            err = ERR_OP32_EXT;
          end else begin
            ok = 1'b1;
            if (f3 == 3'd0) op = OP_ADDW;
            else if (f3 == 3'd1) op = OP_SLLW;
            else if (f3 == 3'd5) op = OP_SRLW;
            else begin
              ok = 1'b0; err = ERR_OP32_FUNCT3;
            end
          end
        end
        OPC_MISC_MEM: begin
          if (f3 == 3'd0) begin
            ok = 1'b1; op = OP_FENCE;
          end else if (f3 == 3'd1 && w == WORD_FENCE_I) begin
            ok = 1'b1; op = OP_FENCE_I;
          end else begin
            err = ERR_MISC_MEM;
          end
        end
        OPC_SYSTEM: begin
          err = ERR_SYSTEM;
          ok = 1'b1;
          if (f3 == 3'd0) begin
            if ((w & SFENCE_MASK) == SFENCE_MATCH) op = OP_SFENCE_VMA;
            else if (w == WORD_ECALL) op = OP_ECALL;
            else if (w == WORD_EBREAK) op = OP_EBREAK;
            else if (w == WORD_SRET) op = OP_SRET;
            else if (w == WORD_MRET) op = OP_MRET;
            else if (w == WORD_WFI) op = OP_WFI;
            else ok = 1'b0;
          end else if (f3 == 3'd4) begin
            ok = 1'b0;
          end else if (f3 < 3'd4) begin
            op = op_t'(6'(OP_CSRRW) + 6'(f3) - 6'd1);
          end else begin
            op = op_t'(6'(OP_CSRRWI) + 6'(f3) - 6'd5);
          end
        end
        default: err = ERR_OPCODE;
      endcase
    end
    d.is_error   = ~ok;
    d.error_code = ok ? ERR_COMPRESSED : err;
    d.operation  = ok ? op : OP_LUI;
    d.imm_value  = ok ? imm : '0;
    d.dest_reg   = w[11:7];
    d.src1_reg   = w[19:15];
    d.src2_reg   = w[24:20];
    d.csr_number = w[31:20];
    d.word_echo  = w;
    return d;
  endfunction

  function automatic logic [6:0] opcode_of(input op_t op);
    if (op == OP_LUI) return OPC_LUI;
    if (op == OP_AUIPC) return OPC_AUIPC;
    if (op == OP_JAL) return OPC_JAL;
    if (op == OP_JALR) return OPC_JALR;
    if (op <= OP_BGEU) return OPC_BRANCH;
    if (op <= OP_LWU) return OPC_LOAD;
    if (op <= OP_SD) return OPC_STORE;
    if (op <= OP_SRAI) return OPC_OP_IMM;
    if (op <= OP_AND) return OPC_OP;
    if (op <= OP_SRAIW) return OPC_OP_IMM32;
    if (op <= OP_SRAW) return OPC_OP_32;
    if (op <= OP_FENCE_I) return OPC_MISC_MEM;
    return OPC_SYSTEM;
  endfunction

  // Random field contents are redrawn until the word decodes to the wanted
  // operation; the funct7 field is biased towards its two legal values.
  function automatic logic [31:0] encode_random(input op_t op);
    logic [31:0] r;
    logic [31:0] w;
    decoded_t    d;
    case (op)
      OP_FENCE_I: return WORD_FENCE_I;
      OP_ECALL:   return WORD_ECALL;
      OP_EBREAK:  return WORD_EBREAK;
      OP_SRET:    return WORD_SRET;
      OP_MRET:    return WORD_MRET;
      OP_WFI:     return WORD_WFI;
      OP_SFENCE_VMA: return SFENCE_MATCH | ($urandom & ~SFENCE_MASK);
      default: ;
    endcase
    forever begin
      r = $urandom;
      case ($urandom_range(2))
        0: r[31:25] = FUNCT7_ZERO;
        1: r[31:25] = FUNCT7_ALT;
        default: ;
      endcase
      w = {r[31:7], opcode_of(op)};
      d = decode_expected(w);
      if (!d.is_error && d.operation == op) return w;
    end
  endfunction

  function automatic logic [31:0] break_word(input logic [31:0] w);
    int unsigned idx;
    idx = $urandom_range(1) ? $urandom_range(14, 12) : $urandom_range(31, 25);
    w[idx] = ~w[idx];
    if ($urandom_range(3) == 0) begin
      idx = $urandom_range(31);
      w[idx] = ~w[idx];
    end
    return w;
  endfunction

  function automatic string describe(input decoded_t d);
    return $sformatf("err=%0b code=%0d op=%0d rd=%0d rs1=%0d rs2=%0d imm=%h csr=%h word=%h",
                     d.is_error, d.error_code, d.operation, d.dest_reg, d.src1_reg,
                     d.src2_reg, d.imm_value, d.csr_number, d.word_echo);
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) out_stall <= receiver_idles && ($urandom_range(99) < 21);

  always @(posedge clk) begin : result_monitor
    decoded_t got;
    decoded_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) pending_decodes.push_back(decode_expected(in_instruction_word));
      if (out_valid && !out_stall) begin
        got.is_error   = out_is_error;
        got.error_code = err_t'(out_error_code);
        got.operation  = op_t'(out_operation_code);
        got.dest_reg   = out_dest_reg;
        got.src1_reg   = out_src1_reg;
        got.src2_reg   = out_src2_reg;
        got.imm_value  = out_imm_value;
        got.csr_number = out_csr_number;
        got.word_echo  = out_word_echo;
        if (pending_decodes.size() == 0) begin
          note_failure({"Result with no transaction outstanding: ", describe(got)});
        end else begin
          want = pending_decodes.pop_front();
          if (got.is_error !== want.is_error || got.error_code !== want.error_code ||
              got.operation !== want.operation || got.dest_reg !== want.dest_reg ||
              got.src1_reg !== want.src1_reg || got.src2_reg !== want.src2_reg ||
              got.imm_value !== want.imm_value || got.csr_number !== want.csr_number ||
              got.word_echo !== want.word_echo)
            note_failure({"Mismatch, expected ", describe(want), "\n            actual   ",
                          describe(got)});
        end
      end
    end
  end

  // Returns at the edge at which the transaction is accepted; valid stays
  // high so that the next transaction can follow without a gap.
  task automatic send_word(input logic [31:0] w);
    if (sender_idles && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 21) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_instruction_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_for_results;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_decodes.size() != 0) @(posedge clk);
  endtask

  task automatic test_special_words;
    send_word(32'h0000_0000);
    send_word(32'hffff_fffe);
    send_word(32'h0000_0001);
    send_word(32'hffff_ffff);
    send_word(32'hffff_f037);
    send_word(32'h8000_006f);
    send_word(32'h7fff_f06f);
    send_word(32'hfff0_0067);
    send_word(32'h8000_0063);
    send_word(32'h0000_2063);
    send_word(32'h03f0_1013);
    send_word(32'h0400_1013);
    send_word(32'h43f0_5013);
    send_word(32'h8000_5013);
    send_word(WORD_FENCE_I);
    send_word(32'h0000_108f);
    send_word(32'hfff0_000f);
    send_word(WORD_ECALL);
    send_word(WORD_EBREAK);
    send_word(WORD_SRET);
    send_word(WORD_MRET);
    send_word(WORD_WFI);
    send_word(32'h13ff_8073);
    send_word(32'h1200_0173);
    send_word(32'h0000_4073);
    send_word(32'hffff_f0f3);
  endtask

  task automatic test_each_operation;
    op_t op;
    for (int pass = 0; pass < 2; pass++) begin
      op = op.first();
      forever begin
        send_word(encode_random(op));
        if (op == op.last()) break;
        op = op.next();
      end
    end
  endtask

  task automatic test_drain_pause;
    for (int n = 0; n < 20; n++) send_word(encode_random(op_t'($urandom_range(OP_CSRRCI))));
    wait_for_results();
    for (int n = 0; n < 20; n++) send_word(encode_random(op_t'($urandom_range(OP_CSRRCI))));
  endtask

  task automatic test_random_mix(input int count);
    logic [31:0] w;
    int unsigned pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        w = encode_random(op_t'($urandom_range(OP_CSRRCI)));
      end else if (pick < 88) begin
        w = break_word(encode_random(op_t'($urandom_range(OP_CSRRCI))));
      end else begin
        w = $urandom;
        if ($urandom_range(2) == 0) w[1:0] = 2'($urandom_range(2));
      end
      send_word(w);
    end
  endtask

  task automatic test_back_to_back;
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    test_random_mix(100);
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_special_words();
    test_each_operation();
    test_drain_pause();
    test_random_mix(350);
    test_back_to_back();
    test_random_mix(60);
    wait_for_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending_decodes.size() == 0) begin
      $display("rv64i_instruction_decoder verification clean");
    end else begin
      $display("rv64i_instruction_decoder verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== rv64i_instruction_decoder.f =====
+incdir+src
src/rv64dec_pkg.sv
src/rv64dec_classify.sv
src/rv64dec_imm_gen.sv
src/rv64i_instruction_decoder.sv
tb/tb.sv
